// ===== rtl/bsae_pkg.sv =====
// ============================================================================
// bsae_pkg: shared definitions for the bytecode stack arithmetic engine
// Opcode and status codes, and the request word to the arithmetic unit.
// ============================================================================
package bsae_pkg;

  // Instruction bytes
  localparam logic [7:0] OP_PUSH = 8'd0;
  localparam logic [7:0] OP_ADD  = 8'd1;
  localparam logic [7:0] OP_SUB  = 8'd2;
  localparam logic [7:0] OP_MUL  = 8'd3;
  localparam logic [7:0] OP_DIV  = 8'd4;
  localparam logic [7:0] OP_NEG  = 8'd5;
  localparam logic [7:0] OP_RET  = 8'd6;

  // Result status codes
  localparam logic [2:0] ST_EXEC  = 3'd0;
  localparam logic [2:0] ST_RET   = 3'd1;
  localparam logic [2:0] ST_BADOP = 3'd2;
  localparam logic [2:0] ST_UNF   = 3'd3;
  localparam logic [2:0] ST_OVF   = 3'd4;

  // Value width (Q format word)
  localparam int unsigned VAL_W = 32;

  // Arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  // Request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

// ===== rtl/bsae_ram.sv =====
// ============================================================================
// bsae_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module bsae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bsae_alu.sv =====
// ============================================================================
// bsae_alu: shared fixed-point arithmetic unit
// Saturating add/subtract, multiply with floor shift, and a one bit per
// cycle restoring divider. A start pulse latches operands; done pulses
// with the result.
// ============================================================================
module bsae_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  bsae_pkg::alu_req_t                      req_i,
  input  logic signed [bsae_pkg::VAL_W-1:0]       a_i,
  input  logic signed [bsae_pkg::VAL_W-1:0]       b_i,
  output logic                                    done_o,
  output logic signed [bsae_pkg::VAL_W-1:0]       res_o
);

  localparam int unsigned W  = bsae_pkg::VAL_W;
  localparam int unsigned DW = W + FRAC_BITS;        // dividend / quotient width
  localparam int unsigned CW = $clog2(DW + 1);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_EXEC = 3'd1;
  localparam logic [2:0] A_MSAT = 3'd2;
  localparam logic [2:0] A_DRUN = 3'd3;
  localparam logic [2:0] A_DFIN = 3'd4;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [DW-1:0] QPOS_LIM = DW'({1'b0, {(W-1){1'b1}}});
  localparam logic [DW-1:0] QNEG_LIM = DW'({1'b1, {(W-1){1'b0}}});

  logic [2:0]              st_q, st_d;
  logic                    done_q, done_d;
  bsae_pkg::alu_op_e       op_q;
  logic signed [W-1:0]     a_q, b_q;
  logic signed [2*W-1:0]   prod_q;
  logic [W-1:0]            rem_q;
  logic [DW-1:0]           quo_q;
  logic [W-1:0]            dvs_q;
  logic                    neg_q;
  logic [CW-1:0]           cnt_q;
  logic signed [W-1:0]     res_q;

  logic signed [W:0]       sum;
  logic signed [W-1:0]     sum_sat;
  logic signed [2*W-1:0]   prod_sh;
  logic signed [W-1:0]     prod_sat;
  logic [W-1:0]            abs_a, abs_b;
  logic [W:0]              shifted, diff;
  logic                    ge;
  logic signed [W-1:0]     quo_res;

  // Saturating add / subtract
  always_comb begin
    if (op_q == bsae_pkg::ALU_SUB) begin
      sum = {a_q[W-1], a_q} - {b_q[W-1], b_q};
    end else begin
      sum = {a_q[W-1], a_q} + {b_q[W-1], b_q};
    end
    if (sum[W] != sum[W-1]) begin
      sum_sat = sum[W] ? VMIN : VMAX;
    end else begin
      sum_sat = sum[W-1:0];
    end
  end

  // Floor shift of the product, then saturate
  always_comb begin
    prod_sh = prod_q >>> FRAC_BITS;
    if (prod_sh > (2*W)'(VMAX)) begin
      prod_sat = VMAX;
    end else if (prod_sh < (2*W)'(VMIN)) begin
      prod_sat = VMIN;
    end else begin
      prod_sat = prod_sh[W-1:0];
    end
  end

  // Operand magnitudes and one restoring division step
  assign abs_a   = a_q[W-1] ? W'(-a_q) : W'(a_q);
  assign abs_b   = b_q[W-1] ? W'(-b_q) : W'(b_q);
  assign shifted = {rem_q, quo_q[DW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  // Quotient sign and saturation
  always_comb begin
    if (neg_q) begin
      quo_res = (quo_q > QNEG_LIM) ? VMIN : W'(-quo_q[W-1:0]);
    end else begin
      quo_res = (quo_q > QPOS_LIM) ? VMAX : quo_q[W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    unique case (st_q)
      A_IDLE: begin
        if (req_i.start) st_d = A_EXEC;
      end
      A_EXEC: begin
        unique case (op_q)
          bsae_pkg::ALU_MUL: st_d = A_MSAT;
          bsae_pkg::ALU_DIV: begin
            if (b_q == '0) begin
              st_d   = A_IDLE;
              done_d = 1'b1;
            end else begin
              st_d = A_DRUN;
            end
          end
          default: begin
            st_d   = A_IDLE;
            done_d = 1'b1;
          end
        endcase
      end
      A_MSAT: begin
        st_d   = A_IDLE;
        done_d = 1'b1;
      end
      A_DRUN: begin
        if (cnt_q == CW'(1)) st_d = A_DFIN;
      end
      A_DFIN: begin
        st_d   = A_IDLE;
        done_d = 1'b1;
      end
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (st_q == A_IDLE && req_i.start) begin
      op_q <= req_i.op;
      a_q  <= a_i;
      b_q  <= b_i;
    end
    case (st_q)
      A_EXEC: begin
        case (op_q)
          bsae_pkg::ALU_MUL: prod_q <= a_q * b_q;
          bsae_pkg::ALU_DIV: begin
            if (b_q == '0) begin
              if (a_q > 0)       res_q <= VMAX;
              else if (a_q < 0)  res_q <= VMIN;
              else               res_q <= '0;
            end
            rem_q <= '0;
            quo_q <= DW'(abs_a) << FRAC_BITS;
            dvs_q <= abs_b;
            neg_q <= a_q[W-1] ^ b_q[W-1];
            cnt_q <= CW'(DW);
          end
          default: res_q <= sum_sat;
        endcase
      end
      A_MSAT: res_q <= prod_sat;
      A_DRUN: begin
        rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
        quo_q <= {quo_q[DW-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
      end
      A_DFIN: res_q <= quo_res;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/bytecode_stack_arith_engine.sv =====
// ============================================================================
// bytecode_stack_arith_engine: bytecode interpreter on a fixed-point stack
// Executes one instruction per input word and returns one result word.
// ============================================================================
// One instruction is taken at a time; in_stall_o stays high until its
// result has been placed in the output register, which then waits for the
// consumer while the next instruction is already accepted. Push, return and
// every error go straight to the output stage; negate, add, subtract and
// multiply wait for the shared arithmetic unit, and divide for its restoring
// divider, which retires one quotient bit per cycle (a zero divisor skips it).
// The top of stack lives in a register; the rest of the stack is a RAM with
// a registered read port, which needs no clearing after reset since only
// entries below the current depth are ever read.
// ============================================================================
module bytecode_stack_arith_engine #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // instruction channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          opcode_i,
  input  logic signed [31:0]                  const_value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          status_o,
  output logic signed [31:0]                  result_value_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]    depth_o
);

  localparam int unsigned W   = bsae_pkg::VAL_W;
  localparam int unsigned CNW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_ALU  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]          st_q, st_d;
  logic [7:0]          op_q, op_d;
  logic [CNW-1:0]      cnt_q, cnt_d;
  logic signed [W-1:0] tos_q, tos_d;
  logic [2:0]          pend_st_q, pend_st_d;
  logic signed [W-1:0] pend_val_q, pend_val_d;
  logic [CNW-1:0]      pend_dep_q, pend_dep_d;

  logic                out_valid_q;
  logic [2:0]          out_st_q;
  logic signed [W-1:0] out_val_q;
  logic [CNW-1:0]      out_dep_q;
  logic                out_free, out_load;

  logic [CNW-1:0]      cnt_m1, cnt_m2;
  logic                ram_we;
  logic [W-1:0]        ram_rdata;

  bsae_pkg::alu_req_t  alu_req;
  logic signed [W-1:0] alu_a;
  logic                alu_done;
  logic signed [W-1:0] alu_res;

  assign cnt_m1 = cnt_q - CNW'(1);
  assign cnt_m2 = cnt_q - CNW'(2);

  // Stack body below the top-of-stack register
  bsae_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_m1[AW-1:0]),
    .wdata_i (tos_q),
    .raddr_i (cnt_m2[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  bsae_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (tos_q),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (st_q == S_EMIT) && out_free;

  // Instruction sequencer
  always_comb begin
    st_d       = st_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    tos_d      = tos_q;
    pend_st_d  = pend_st_q;
    pend_val_d = pend_val_q;
    pend_dep_d = pend_dep_q;
    ram_we     = 1'b0;
    alu_req    = '{start: 1'b0, op: bsae_pkg::ALU_ADD};
    alu_a      = ram_rdata;
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = opcode_i;
          st_d       = S_EMIT;
          pend_val_d = '0;
          pend_dep_d = '0;
          case (opcode_i) inside
            bsae_pkg::OP_PUSH: begin
              if (cnt_q == CNW'(STACK_DEPTH)) begin
                pend_st_d = bsae_pkg::ST_OVF;
                cnt_d     = '0;
              end else begin
                // spill the old top into the RAM
                ram_we     = (cnt_q != '0);
                tos_d      = const_value_i;
                cnt_d      = cnt_q + CNW'(1);
                pend_st_d  = bsae_pkg::ST_EXEC;
                pend_val_d = const_value_i;
                pend_dep_d = cnt_q + CNW'(1);
              end
            end
            bsae_pkg::OP_ADD, bsae_pkg::OP_SUB, bsae_pkg::OP_MUL, bsae_pkg::OP_DIV: begin
              if (cnt_q < CNW'(2)) begin
                pend_st_d = bsae_pkg::ST_UNF;
                cnt_d     = '0;
              end else begin
                st_d = S_RD;
              end
            end
            bsae_pkg::OP_NEG: begin
              if (cnt_q == '0) begin
                pend_st_d = bsae_pkg::ST_UNF;
              end else begin
                // negate as 0 - top
                alu_req = '{start: 1'b1, op: bsae_pkg::ALU_SUB};
                alu_a   = '0;
                st_d    = S_ALU;
              end
            end
            bsae_pkg::OP_RET: begin
              if (cnt_q == '0) begin
                pend_st_d = bsae_pkg::ST_UNF;
              end else begin
                pend_st_d  = bsae_pkg::ST_RET;
                pend_val_d = tos_q;
                cnt_d      = '0;
              end
            end
            default: begin
              pend_st_d = bsae_pkg::ST_BADOP;
              cnt_d     = '0;
            end
          endcase
        end
      end
      S_RD: begin
        // second operand is now on the RAM read port
        case (op_q)
          bsae_pkg::OP_ADD: alu_req = '{start: 1'b1, op: bsae_pkg::ALU_ADD};
          bsae_pkg::OP_SUB: alu_req = '{start: 1'b1, op: bsae_pkg::ALU_SUB};
          bsae_pkg::OP_MUL: alu_req = '{start: 1'b1, op: bsae_pkg::ALU_MUL};
          default:          alu_req = '{start: 1'b1, op: bsae_pkg::ALU_DIV};
        endcase
        st_d = S_ALU;
      end
      S_ALU: begin
        if (alu_done) begin
          tos_d      = alu_res;
          pend_st_d  = bsae_pkg::ST_EXEC;
          pend_val_d = alu_res;
          if (op_q == bsae_pkg::OP_NEG) begin
            pend_dep_d = cnt_q;
          end else begin
            cnt_d      = cnt_m1;
            pend_dep_d = cnt_m1;
          end
          st_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    tos_q      <= tos_d;
    pend_st_q  <= pend_st_d;
    pend_val_q <= pend_val_d;
    pend_dep_q <= pend_dep_d;
    if (out_load) begin
      out_st_q  <= pend_st_q;
      out_val_q <= pend_val_q;
      out_dep_q <= pend_dep_q;
    end
  end

  assign in_stall_o     = (st_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign result_value_o = out_val_q;
  assign depth_o        = out_dep_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_alu_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> st_q == S_ALU)
    else $error("arithmetic result with no instruction waiting");

  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bsae_pkg::ST_EXEC |-> depth_o == '0)
    else $error("return or error left values on the stack");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && pend_st_q != bsae_pkg::ST_EXEC && pend_st_q != bsae_pkg::ST_RET
      |=> result_value_o == '0)
    else $error("error word carries a nonzero value");

endmodule
